[src/gdc_pkg.sv]
package gdc_pkg;

    localparam int DIST_BITS = 28;
    localparam int PREV_BITS = 12;
    localparam int VCNT_BITS = 13;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_QUERY = 2'd2;

    localparam logic [3:0] REG_EXTENT_X = 4'd0;
    localparam logic [3:0] REG_EXTENT_Y = 4'd4;

    // Datapath operation requested by the controller for one cycle.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_QRD,
        OP_QOUT,
        OP_CLR,
        OP_SRC,
        OP_SCAN_START,
        OP_SCAN,
        OP_SETTLE,
        OP_NB_RD,
        OP_NB_UPD,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] nb;
    } dp_cmd_t;

    typedef struct packed {
        logic cell_ok;
        logic clr_last;
        logic scan_last;
        logic found;
        logic nb_ok;
    } dp_stat_t;

endpackage

[src/gdc_ram.sv]
module gdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/gdc_ctrl.sv]
module gdc_ctrl
    import gdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [1:0] in_mode,
    input  logic       out_busy,
    input  dp_stat_t   stat,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QOUT, S_CLR, S_SRC, S_SCAN0, S_SCAN, S_SETTLE,
        S_NBRD, S_NBUPD, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] nb_reg, nb_next;

    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        nb_next    = nb_reg;
        cmd.op     = OP_IDLE;
        cmd.nb     = nb_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_mode)
                        MODE_LOAD:  cmd.op = OP_LOAD;
                        MODE_RUN:   state_next = S_CLR;
                        MODE_QUERY: state_next = S_QRD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_QRD:
            begin
                cmd.op = OP_QRD;
                state_next = S_QOUT;
            end
            S_QOUT:
            begin
                cmd.op = OP_QOUT;
                state_next = S_IDLE;
            end
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (stat.clr_last)
                begin
                    state_next = stat.cell_ok ? S_SRC : S_DONE;
                end
            end
            S_SRC:
            begin
                cmd.op = OP_SRC;
                state_next = S_SCAN0;
            end
            S_SCAN0:
            begin
                cmd.op = OP_SCAN_START;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                cmd.op = OP_SETTLE;
                nb_next = 2'd0;
                state_next = stat.found ? S_NBRD : S_DONE;
            end
            S_NBRD:
            begin
                cmd.op = OP_NB_RD;
                if (stat.nb_ok)
                begin
                    state_next = S_NBUPD;
                end
                else if (nb_reg == 2'd3)
                begin
                    state_next = S_SCAN0;
                end
                else
                begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            S_NBUPD:
            begin
                cmd.op = OP_NB_UPD;
                nb_next = nb_reg + 2'd1;
                state_next = (nb_reg == 2'd3) ? S_SCAN0 : S_NBRD;
            end
            S_DONE:
            begin
                cmd.op = OP_DONE;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nb_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
        end
    end

endmodule

[src/gdc_dp.sv]
module gdc_dp
    import gdc_pkg::*;
#(
    parameter int MAX_EXTENT_X = 64,
    parameter int MAX_EXTENT_Y = 64,
    parameter int COST_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic                 in_fire,
    input  logic [5:0]           in_x,
    input  logic [5:0]           in_y,
    input  logic signed [15:0]   in_cost,
    input  logic [6:0]           ext_x_raw,
    input  logic [6:0]           ext_y_raw,
    input  logic                 out_take,
    output logic                 out_busy,
    output logic [2*8+5*8-1:0]   out_word,
    output dp_stat_t             stat
);

    localparam int CELLS = MAX_EXTENT_X * MAX_EXTENT_Y;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_EXTENT_X + 1);
    localparam int YW    = $clog2(MAX_EXTENT_Y + 1);
    localparam int CW    = AW + 1;
    localparam int SW    = ((COST_BITS > DIST_BITS) ? COST_BITS : DIST_BITS) + 2;
    localparam longint DMAX_L = (longint'(1) << (DIST_BITS - 1)) - 1;
    localparam logic signed [SW-1:0] CAND_HI = SW'(DMAX_L);
    localparam logic signed [SW-1:0] CAND_LO = SW'(-DMAX_L - 1);

    logic [XW-1:0] ex, ey_x;
    logic [YW-1:0] ey;
    always_comb
    begin
        if (ext_x_raw == 7'd0) ex = XW'(1);
        else if (32'(ext_x_raw) > MAX_EXTENT_X) ex = XW'(MAX_EXTENT_X);
        else ex = XW'(ext_x_raw);
        if (ext_y_raw == 7'd0) ey = YW'(1);
        else if (32'(ext_y_raw) > MAX_EXTENT_Y) ey = YW'(MAX_EXTENT_Y);
        else ey = YW'(ext_y_raw);
        ey_x = '0;
    end

    logic inside_in;
    logic [AW-1:0] idx_in;
    assign inside_in = (32'(in_x) < 32'(ex)) && (32'(in_y) < 32'(ey));
    assign idx_in = AW'(32'(in_x) * 32'(ey) + 32'(in_y));

    logic [CW-1:0] total;
    assign total = CW'(32'(ex) * 32'(ey));

    // operation registers
    logic [AW-1:0] cell_reg;
    logic          inside_reg;
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;
    logic [CW-1:0] ptr_reg;
    logic [XW-1:0] sx_reg;
    logic [YW-1:0] sy_reg;
    logic [AW-1:0] best_reg;
    logic [XW-1:0] bestx_reg;
    logic [YW-1:0] besty_reg;
    logic signed [DIST_BITS-1:0] bestd_reg;
    logic          found_reg;
    logic [VCNT_BITS-1:0] cnt_reg;
    logic [AW-1:0] u_reg;
    logic [XW-1:0] ux_reg;
    logic [YW-1:0] uy_reg;
    logic signed [DIST_BITS-1:0] du_reg;
    logic [AW-1:0] v_reg;
    logic          scan_v_reg;
    logic [AW-1:0] scan_a_reg;
    logic [XW-1:0] scan_x_reg;
    logic [YW-1:0] scan_y_reg;
    logic [AW-1:0] clr_reg;
    logic          ran_reg;

    // memories
    logic                        c_we;
    logic [AW-1:0]               c_raddr;
    logic signed [COST_BITS-1:0] c_rdata;
    logic                        d_we;
    logic [AW-1:0]               d_waddr, d_raddr;
    logic signed [DIST_BITS-1:0] d_wdata, d_rdata;
    logic                        p_we;
    logic [AW-1:0]               p_waddr, p_raddr;
    logic [PREV_BITS-1:0]        p_wdata, p_rdata;
    logic                        rm_we;
    logic [AW-1:0]               rm_waddr, rm_raddr;
    logic                        rm_wdata, rm_rdata;
    logic                        vm_we;
    logic [AW-1:0]               vm_waddr, vm_raddr;
    logic                        vm_wdata, vm_rdata;

    gdc_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost (
        .clk(clk), .we(c_we), .waddr(idx_in), .wdata(COST_BITS'(in_cost)),
        .raddr(c_raddr), .rdata(c_rdata));
    gdc_ram #(.WIDTH(DIST_BITS), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata));
    gdc_ram #(.WIDTH(PREV_BITS), .DEPTH(CELLS)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));
    // reached and visited marks, cleared by a pass at the start of each run
    gdc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_reach (
        .clk(clk), .we(rm_we), .waddr(rm_waddr), .wdata(rm_wdata),
        .raddr(rm_raddr), .rdata(rm_rdata));
    gdc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit (
        .clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
        .raddr(vm_raddr), .rdata(vm_rdata));

    // neighbour selection
    logic          nb_ok;
    logic [AW-1:0] nb_addr;
    always_comb
    begin
        nb_ok = 1'b0;
        nb_addr = u_reg;
        case (cmd.nb)
            2'd0:
            begin
                nb_ok = ux_reg != '0;
                nb_addr = u_reg - AW'(ey);
            end
            2'd1:
            begin
                nb_ok = uy_reg != '0;
                nb_addr = u_reg - AW'(1);
            end
            2'd2:
            begin
                nb_ok = 32'(ux_reg) + 1 < 32'(ex);
                nb_addr = u_reg + AW'(ey);
            end
            default:
            begin
                nb_ok = 32'(uy_reg) + 1 < 32'(ey);
                nb_addr = u_reg + AW'(1);
            end
        endcase
    end

    logic signed [SW-1:0]        cand_w;
    logic signed [DIST_BITS-1:0] cand;
    always_comb
    begin
        cand_w = SW'(du_reg) + SW'(c_rdata);
        if (cand_w > CAND_HI)
            cand = CAND_HI[DIST_BITS-1:0];
        else if (cand_w < CAND_LO)
            cand = CAND_LO[DIST_BITS-1:0];
        else
            cand = cand_w[DIST_BITS-1:0];
    end

    logic [AW-1:0] ptr_a;
    assign ptr_a = ptr_reg[AW-1:0];

    logic clr_last;
    assign clr_last = clr_reg == AW'(CELLS - 1);

    logic q_hit;
    assign q_hit = inside_reg && ran_reg && rm_rdata;

    always_comb
    begin
        c_we = cmd.op == OP_LOAD && in_fire && inside_in;
        c_raddr = nb_addr;
        d_we = 1'b0; d_waddr = v_reg; d_wdata = cand;
        p_we = 1'b0; p_waddr = v_reg; p_wdata = PREV_BITS'(u_reg);
        d_raddr = ptr_a; p_raddr = cell_reg;
        rm_we = 1'b0; rm_waddr = v_reg; rm_wdata = 1'b1; rm_raddr = ptr_a;
        vm_we = 1'b0; vm_waddr = best_reg; vm_wdata = 1'b1; vm_raddr = ptr_a;
        case (cmd.op)
            OP_QRD:
            begin
                d_raddr = cell_reg;
                rm_raddr = cell_reg;
            end
            OP_CLR:
            begin
                rm_we = 1'b1; rm_waddr = clr_reg; rm_wdata = 1'b0;
                vm_we = 1'b1; vm_waddr = clr_reg; vm_wdata = 1'b0;
            end
            OP_SRC:
            begin
                d_we = 1'b1; d_waddr = cell_reg; d_wdata = '0;
                p_we = 1'b1; p_waddr = cell_reg; p_wdata = PREV_BITS'(cell_reg);
                rm_we = 1'b1; rm_waddr = cell_reg;
            end
            OP_SETTLE:
            begin
                d_raddr = best_reg;
                vm_we = found_reg;
            end
            OP_NB_RD:
            begin
                d_raddr = nb_addr;
                rm_raddr = nb_addr;
            end
            OP_NB_UPD:
            begin
                if (!rm_rdata || d_rdata > cand)
                begin
                    d_we = 1'b1; p_we = 1'b1; rm_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic [1:0]                  o_st_reg;
    logic                        o_rch_reg;
    logic signed [DIST_BITS-1:0] o_d_reg;
    logic [PREV_BITS-1:0]        o_p_reg;
    logic [VCNT_BITS-1:0]        o_c_reg;
    logic                        busy_reg;

    assign out_busy = busy_reg;
    assign out_word = {o_c_reg, o_p_reg, o_d_reg, o_rch_reg, o_st_reg};

    assign stat.cell_ok   = inside_reg;
    assign stat.clr_last  = clr_last;
    assign stat.scan_last = ptr_reg == total;
    assign stat.found     = found_reg;
    assign stat.nb_ok     = nb_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            scan_v_reg <= 1'b0;
            clr_reg   <= '0;
            ran_reg   <= 1'b0;
        end
        else
        begin
            if (out_take) busy_reg <= 1'b0;
            if (in_fire)
            begin
                cell_reg   <= inside_in ? idx_in : '0;
                inside_reg <= inside_in;
                cx_reg     <= XW'(in_x);
                cy_reg     <= YW'(in_y);
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    busy_reg <= 1'b1;
                    o_st_reg <= ST_LOAD; o_rch_reg <= 1'b0; o_d_reg <= '0;
                    o_p_reg <= '0; o_c_reg <= '0;
                end
                OP_QOUT:
                begin
                    busy_reg <= 1'b1;
                    o_st_reg <= ST_QUERY; o_rch_reg <= q_hit;
                    o_d_reg <= q_hit ? d_rdata : '0;
                    o_p_reg <= q_hit ? p_rdata : '0;
                    o_c_reg <= '0;
                end
                OP_CLR:
                begin
                    cnt_reg <= '0;
                    ran_reg <= 1'b1;
                    clr_reg <= clr_last ? '0 : clr_reg + AW'(1);
                end
                OP_SCAN_START:
                begin
                    ptr_reg <= '0; found_reg <= 1'b0; scan_v_reg <= 1'b0;
                    sx_reg <= '0; sy_reg <= '0;
                end
                OP_SCAN:
                begin
                    // one cell read per cycle, compare the previous read
                    if (ptr_reg != total)
                    begin
                        ptr_reg <= ptr_reg + CW'(1);
                        if (32'(sy_reg) + 1 == 32'(ey))
                        begin
                            sy_reg <= '0;
                            sx_reg <= sx_reg + XW'(1);
                        end
                        else
                        begin
                            sy_reg <= sy_reg + YW'(1);
                        end
                    end
                    scan_v_reg <= ptr_reg != total;
                    scan_a_reg <= ptr_a;
                    scan_x_reg <= sx_reg;
                    scan_y_reg <= sy_reg;
                    if (scan_v_reg && rm_rdata && !vm_rdata &&
                        (!found_reg || d_rdata < bestd_reg))
                    begin
                        found_reg <= 1'b1; best_reg <= scan_a_reg; bestd_reg <= d_rdata;
                        bestx_reg <= scan_x_reg; besty_reg <= scan_y_reg;
                    end
                end
                OP_SETTLE:
                begin
                    if (found_reg)
                    begin
                        cnt_reg <= cnt_reg + VCNT_BITS'(1);
                        u_reg <= best_reg;
                        ux_reg <= bestx_reg;
                        uy_reg <= besty_reg;
                        du_reg <= bestd_reg;
                    end
                end
                OP_NB_RD: v_reg <= nb_addr;
                OP_DONE:
                begin
                    busy_reg <= 1'b1;
                    o_st_reg <= ST_RUN; o_rch_reg <= 1'b0; o_d_reg <= '0;
                    o_p_reg <= '0; o_c_reg <= cnt_reg;
                end
                default: ;
            endcase
        end
    end

    logic unused;
    assign unused = ^{cx_reg, cy_reg, ey_x};

endmodule

[src/grid_dijkstra_cell_cost.sv]
// Grid shortest-path engine over a 4-neighbour grid.
// s_axis: one word per command. tdata = {cell_cost, cell_y, cell_x},
//   tuser = mode (0 load cost, 1 run from source, 2 query).
// m_axis: one word per command. tdata = {visited_count, prev_index,
//   distance, reached, status}.
// APB: extent_x at 0x0, extent_y at 0x4; write only while idle.
// Load: result in the next cycle after accept. Query: the cell is read in state
//   QRD and the result is registered in state QOUT. Run: a clearing pass over
//   every mark entry, then, if the source cell lies inside the grid, per
//   settled cell one scan of the grid (one cell per cycle through the RAM read
//   ports), a settle step, a read step per neighbour and an update step per
//   neighbour inside the grid, and one last empty scan.
// Only one command is in flight; s_axis_tready drops while busy and while
//   an unread result is held. A stalled receiver holds the result.
// Reset drops any held result and makes every cell read as unreached until
//   the first run; the extents go to 64; costs, distances and predecessors
//   are undefined until written.
module grid_dijkstra_cell_cost
    import gdc_pkg::*;
#(
    parameter int MAX_EXTENT_X = 64,
    parameter int MAX_EXTENT_Y = 64,
    parameter int COST_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cell_x[5:0], cell_y[11:6], cell_cost[27:12]
    input  logic [1:0]  s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // status, reached, distance, prev_index, visited_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] ext_x_reg, ext_y_reg;
    logic       in_fire, out_busy;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    assign pready = 1'b1;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_busy;

    always_comb
    begin
        unique case ({1'b0, paddr})
            REG_EXTENT_X: prdata = {25'd0, ext_x_reg};
            REG_EXTENT_Y: prdata = {25'd0, ext_y_reg};
            default:      prdata = '0;
        endcase
    end

    // take register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg <= 7'd64;
            ext_y_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            if ({1'b0, paddr} == REG_EXTENT_X) ext_x_reg <= pwdata[6:0];
            if ({1'b0, paddr} == REG_EXTENT_Y) ext_y_reg <= pwdata[6:0];
        end
    end

    gdc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_mode(s_axis_tuser),
        .out_busy(out_busy), .stat(stat), .in_ready(s_axis_tready), .cmd(cmd));

    gdc_dp #(
        .MAX_EXTENT_X(MAX_EXTENT_X), .MAX_EXTENT_Y(MAX_EXTENT_Y),
        .COST_BITS(COST_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_fire(in_fire),
        .in_x(s_axis_tdata[5:0]), .in_y(s_axis_tdata[11:6]),
        .in_cost(s_axis_tdata[27:12]), .ext_x_raw(ext_x_reg),
        .ext_y_raw(ext_y_reg), .out_take(m_axis_tvalid && m_axis_tready),
        .out_busy(out_busy), .out_word(m_axis_tdata), .stat(stat));

    logic unused;
    assign unused = ^s_axis_tdata[31:28];

endmodule
